// ----- sv/assert_macros.svh -----
// Assertion macros for the RTL, included by the core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define SBC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define SBC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define SBC_ASSERT(lbl, clk, rstn, prop)
`define SBC_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- sv/sbc_pkg.sv -----
// Shared types and constants of the stack bytecode core.
package sbc_pkg;

  localparam int PC_W   = 16;
  localparam int WORD_W = 32;
  localparam int CLEN_W = 17;

  typedef enum logic [4:0] {
    OP_POS = 5'd0, OP_NEG = 5'd1, OP_LNOT = 5'd2, OP_BNOT = 5'd3,
    OP_ADD = 5'd4, OP_SUB = 5'd5, OP_MUL = 5'd6, OP_DIV = 5'd7, OP_MOD = 5'd8,
    OP_EQ = 5'd9, OP_NEQ = 5'd10, OP_LT = 5'd11, OP_LTE = 5'd12, OP_GT = 5'd13,
    OP_GTE = 5'd14, OP_OR = 5'd15, OP_XOR = 5'd16, OP_AND = 5'd17,
    OP_SHL = 5'd18, OP_SHR = 5'd19, OP_LAND = 5'd20, OP_LOR = 5'd21,
    OP_LOAD = 5'd22, OP_STL = 5'd23, OP_INT = 5'd24, OP_JUMP = 5'd25,
    OP_BRZ = 5'd26, OP_SPSET = 5'd27, OP_CALL = 5'd28, OP_RET = 5'd29,
    OP_RSV0 = 5'd30, OP_RSV1 = 5'd31
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DIV_ZERO = 3'd1,
    ST_UNDER    = 3'd2,
    ST_OVER     = 3'd3,
    ST_DEPTH    = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RDA, S_RDB, S_EXE, S_DIV, S_DIVW, S_TOPRD, S_TOPCAP, S_DONE
  } fsm_t;

  localparam logic CFG_CODE_LEN = 1'b0;
  localparam logic CFG_ENTRY_PC = 1'b1;

  localparam logic [WORD_W-1:0] END_VALUE = '1;

  function automatic logic [WORD_W-1:0] binop(input opcode_t m,
                                               input logic [WORD_W-1:0] a,
                                               input logic [WORD_W-1:0] b);
    logic [WORD_W-1:0] r;
    r = '0;
    case (m)
      OP_ADD:  r = a + b;
      OP_SUB:  r = a - b;
      OP_MUL:  r = a * b;
      OP_EQ:   r = {31'd0, a == b};
      OP_NEQ:  r = {31'd0, a != b};
      OP_LT:   r = {31'd0, $signed(a) < $signed(b)};
      OP_LTE:  r = {31'd0, $signed(a) <= $signed(b)};
      OP_GT:   r = {31'd0, $signed(a) > $signed(b)};
      OP_GTE:  r = {31'd0, $signed(a) >= $signed(b)};
      OP_OR:   r = a | b;
      OP_XOR:  r = a ^ b;
      OP_AND:  r = a & b;
      OP_SHL:  r = a << b[4:0];
      OP_SHR:  r = $unsigned($signed(a) >>> b[4:0]);
      OP_LAND: r = {31'd0, (a != '0) && (b != '0)};
      OP_LOR:  r = {31'd0, (a != '0) || (b != '0)};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- sv/sbc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module sbc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- sv/stack_bytecode_core.sv -----
// Stack bytecode core: operand stack and call frames held in synchronous RAMs.
// Each request steps through RDA, RDB, EXE, TOPRD, TOPCAP and DONE; div and mod
// with a nonzero divisor add DIV and DIVW after EXE (bit-serial divider, one quotient
// bit per cycle). A new request is taken while the last result waits; DONE holds until it is taken.
// Reset (synchronous, rst_n low): sp, frame base, call depth, halt, pc and
// code_length clear; RAM contents are left as they are.
`include "assert_macros.svh"
module stack_bytecode_core #(
  parameter int STACK_WORDS = 256,
  parameter int CALL_DEPTH  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [4:0]  in_mode,
  input  logic [31:0] in_operand_a,
  input  logic [15:0] in_operand_b,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_next_pc,
  output logic [31:0] out_top_value,
  output logic        out_halted,
  output logic [31:0] out_return_value,
  output logic [2:0]  out_status,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [16:0] cfg_wdata
);
  localparam int AW  = $clog2(STACK_WORDS);
  localparam int SPW = $clog2(STACK_WORDS + 1);
  localparam int FAW = (CALL_DEPTH > 1) ? $clog2(CALL_DEPTH) : 1;
  localparam int DW  = $clog2(CALL_DEPTH + 1);
  localparam int FW  = sbc_pkg::PC_W + SPW;
  localparam logic [SPW-1:0] SP_FULL  = SPW'(STACK_WORDS);
  localparam logic [DW-1:0]  DEPTH_MAX = DW'(CALL_DEPTH);

  // architectural state
  sbc_pkg::fsm_t    state_r, state_nxt;
  logic [SPW-1:0]   sp_r, sp_nxt, fp_r, fp_nxt;
  logic [DW-1:0]    depth_r, depth_nxt;
  logic [15:0]      pc_r, pc_nxt;
  logic             halt_r, halt_nxt;
  logic [31:0]      final_r, final_nxt;
  sbc_pkg::status_t st_r, st_nxt;
  logic [16:0]      code_len_r;

  // latched request
  sbc_pkg::opcode_t m_r;
  logic [31:0]      a_r, opa_r, top_r;
  logic [15:0]      b_r;

  // RAM ports
  logic             s_we, f_we;
  logic [AW-1:0]    s_wa, s_ra;
  logic [31:0]      s_wd, s_rd;
  logic [FW-1:0]    f_wd, f_rd;

  // divider
  logic [31:0]      dq_r, dvs_r;
  logic [32:0]      drem_r, rem_sh;
  logic [4:0]       dcnt_r;
  logic             qneg_r, rneg_r, is_mod_r, div_start;
  logic [31:0]      div_res;

  // address helpers
  logic [AW-1:0]    sp_m1, sp_m2;
  logic signed [33:0] lt;
  logic             l_neg, l_over;
  logic [SPW-1:0]   avail;
  logic [15:0]      npc_rel;
  logic [31:0]      unres, bres, opb;
  logic signed [33:0] adj_t;
  logic [32:0]      cnt;

  assign sp_m1   = AW'(sp_r - SPW'(1));
  assign sp_m2   = AW'(sp_r - SPW'(2));
  assign lt      = $signed({{(34 - SPW){1'b0}}, fp_r}) + {{2{a_r[31]}}, a_r};
  assign l_neg   = lt[33];
  assign l_over  = !l_neg && (lt >= 34'(STACK_WORDS));
  assign avail   = sp_r - fp_r;
  assign npc_rel = pc_r + 16'd1 + a_r[15:0];
  assign opb     = s_rd;
  assign adj_t   = $signed({{(34 - SPW){1'b0}}, fp_r}) + {{2{a_r[31]}}, a_r};
  assign cnt     = a_r[31] ? 33'd0 :
                   ({1'b0, a_r} > 33'(avail)) ? 33'(avail) : {1'b0, a_r};

  always_comb begin
    case (m_r[1:0])
      2'd0:    unres = opa_r;
      2'd1:    unres = 32'd0 - opa_r;
      2'd2:    unres = {31'd0, opa_r == 32'd0};
      default: unres = ~opa_r;
    endcase
  end
  assign bres = sbc_pkg::binop(m_r, opa_r, opb);

  // restoring divider step on magnitudes
  assign rem_sh  = {drem_r[31:0], dq_r[31]};
  assign div_res = is_mod_r ? (rneg_r ? 32'd0 - drem_r[31:0] : drem_r[31:0])
                            : (qneg_r ? 32'd0 - dq_r : dq_r);

  sbc_ram #(.WIDTH(32), .DEPTH(STACK_WORDS)) u_stack (
    .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd)
  );

  // frame RAM is read at the current top frame; call writes at depth
  sbc_ram #(.WIDTH(FW), .DEPTH(CALL_DEPTH)) u_frames (
    .clk(clk), .we(f_we), .waddr(FAW'(depth_r)), .wdata(f_wd),
    .raddr(FAW'(depth_r - DW'(1))), .rdata(f_rd)
  );

  assign in_ready = (state_r == sbc_pkg::S_IDLE);

  always_comb begin
    state_nxt = state_r;
    sp_nxt    = sp_r;
    fp_nxt    = fp_r;
    depth_nxt = depth_r;
    pc_nxt    = pc_r;
    halt_nxt  = halt_r;
    final_nxt = final_r;
    st_nxt    = st_r;
    s_we      = 1'b0;
    s_wa      = sp_r[AW-1:0];
    s_wd      = 32'd0;
    s_ra      = sp_m1;
    f_we      = 1'b0;
    f_wd      = {pc_r, fp_r};
    div_start = 1'b0;
    case (state_r)
      sbc_pkg::S_IDLE: begin
        if (in_valid) state_nxt = sbc_pkg::S_RDA;
      end
      sbc_pkg::S_RDA: begin
        // load fetches the local, binary ops the lower operand, others the top
        if (m_r == sbc_pkg::OP_LOAD) s_ra = lt[AW-1:0];
        else if (m_r >= sbc_pkg::OP_ADD && m_r <= sbc_pkg::OP_LOR) s_ra = sp_m2;
        state_nxt = sbc_pkg::S_RDB;
      end
      sbc_pkg::S_RDB: begin
        state_nxt = sbc_pkg::S_EXE;
      end
      sbc_pkg::S_EXE: begin
        state_nxt = sbc_pkg::S_TOPRD;
        st_nxt    = sbc_pkg::ST_OK;
        if (halt_r) begin
          // hold everything, repeat the last result with status OK
        end else if ({1'b0, pc_r} >= code_len_r) begin
          halt_nxt  = 1'b1;
          final_nxt = sbc_pkg::END_VALUE;
        end else begin
          pc_nxt = pc_r + 16'd1;
          if (m_r <= sbc_pkg::OP_BNOT) begin
            if (avail < SPW'(1)) st_nxt = sbc_pkg::ST_UNDER;
            else begin
              s_we = 1'b1; s_wa = sp_m1; s_wd = unres;
            end
          end else if (m_r <= sbc_pkg::OP_LOR) begin
            if (avail < SPW'(2)) st_nxt = sbc_pkg::ST_UNDER;
            else begin
              sp_nxt = sp_r - SPW'(1);
              if ((m_r == sbc_pkg::OP_DIV || m_r == sbc_pkg::OP_MOD) && opb != 32'd0) begin
                div_start = 1'b1;
                state_nxt = sbc_pkg::S_DIV;
              end else begin
                if (m_r == sbc_pkg::OP_DIV || m_r == sbc_pkg::OP_MOD)
                  st_nxt = sbc_pkg::ST_DIV_ZERO;
                s_we = 1'b1; s_wa = sp_m2;
                s_wd = (m_r == sbc_pkg::OP_DIV || m_r == sbc_pkg::OP_MOD) ? 32'd0 : bres;
              end
            end
          end else begin
            case (m_r)
              sbc_pkg::OP_LOAD: begin
                pc_nxt = pc_r + 16'd2;
                if (l_neg) st_nxt = sbc_pkg::ST_UNDER;
                else if (l_over) st_nxt = sbc_pkg::ST_OVER;
                if (sp_r >= SP_FULL) st_nxt = sbc_pkg::ST_OVER;
                else begin
                  s_we = 1'b1; s_wa = sp_r[AW-1:0];
                  s_wd = (l_neg || l_over) ? 32'd0 : opa_r;
                  sp_nxt = sp_r + SPW'(1);
                end
              end
              sbc_pkg::OP_STL: begin
                pc_nxt = pc_r + 16'd2;
                if (avail < SPW'(1)) st_nxt = sbc_pkg::ST_UNDER;
                else begin
                  sp_nxt = sp_r - SPW'(1);
                  if (l_neg) st_nxt = sbc_pkg::ST_UNDER;
                  else if (l_over) st_nxt = sbc_pkg::ST_OVER;
                  else begin
                    s_we = 1'b1; s_wa = lt[AW-1:0]; s_wd = opa_r;
                  end
                end
              end
              sbc_pkg::OP_INT: begin
                pc_nxt = pc_r + 16'd2;
                if (sp_r >= SP_FULL) st_nxt = sbc_pkg::ST_OVER;
                else begin
                  s_we = 1'b1; s_wa = sp_r[AW-1:0]; s_wd = a_r;
                  sp_nxt = sp_r + SPW'(1);
                end
              end
              sbc_pkg::OP_JUMP: pc_nxt = npc_rel;
              sbc_pkg::OP_BRZ: begin
                pc_nxt = pc_r + 16'd2;
                if (avail < SPW'(1)) st_nxt = sbc_pkg::ST_UNDER;
                else begin
                  sp_nxt = sp_r - SPW'(1);
                  if (opa_r == 32'd0) pc_nxt = npc_rel;
                end
              end
              sbc_pkg::OP_SPSET: begin
                pc_nxt = pc_r + 16'd2;
                if (a_r[31]) begin
                  st_nxt = sbc_pkg::ST_UNDER; sp_nxt = fp_r;
                end else if (adj_t > 34'(STACK_WORDS)) begin
                  st_nxt = sbc_pkg::ST_OVER; sp_nxt = SP_FULL;
                end else sp_nxt = SPW'(adj_t);
              end
              sbc_pkg::OP_CALL: begin
                pc_nxt = pc_r + 16'd3;
                if (depth_r >= DEPTH_MAX) st_nxt = sbc_pkg::ST_DEPTH;
                else begin
                  if (a_r[31] || {1'b0, a_r} > 33'(avail)) st_nxt = sbc_pkg::ST_UNDER;
                  f_we      = 1'b1;
                  f_wd      = {pc_r + 16'd3, fp_r};
                  depth_nxt = depth_r + DW'(1);
                  fp_nxt    = sp_r - SPW'(cnt);
                  pc_nxt    = b_r;
                end
              end
              sbc_pkg::OP_RET: begin
                if (avail < SPW'(1)) st_nxt = sbc_pkg::ST_UNDER;
                if (depth_r == '0) begin
                  halt_nxt  = 1'b1;
                  final_nxt = (avail < SPW'(1)) ? 32'd0 : opa_r;
                  pc_nxt    = pc_r;
                end else begin
                  if (fp_r >= SP_FULL) begin
                    st_nxt = sbc_pkg::ST_OVER; sp_nxt = fp_r;
                  end else begin
                    s_we = 1'b1; s_wa = fp_r[AW-1:0];
                    s_wd = (avail < SPW'(1)) ? 32'd0 : opa_r;
                    sp_nxt = fp_r + SPW'(1);
                  end
                  depth_nxt = depth_r - DW'(1);
                  fp_nxt    = f_rd[SPW-1:0];
                  pc_nxt    = f_rd[FW-1:SPW];
                end
              end
              default: ;
            endcase
          end
          // running off the end of code halts with the end marker
          if (!halt_nxt && {1'b0, pc_nxt} >= code_len_r) begin
            halt_nxt  = 1'b1;
            final_nxt = sbc_pkg::END_VALUE;
          end
        end
      end
      sbc_pkg::S_DIV: begin
        if (dcnt_r == 5'd31) state_nxt = sbc_pkg::S_DIVW;
      end
      sbc_pkg::S_DIVW: begin
        s_we = 1'b1; s_wa = sp_m1; s_wd = div_res;
        state_nxt = sbc_pkg::S_TOPRD;
      end
      sbc_pkg::S_TOPRD:  state_nxt = sbc_pkg::S_TOPCAP;
      sbc_pkg::S_TOPCAP: state_nxt = sbc_pkg::S_DONE;
      sbc_pkg::S_DONE: begin
        if (!out_valid || out_ready) state_nxt = sbc_pkg::S_IDLE;
      end
      default: state_nxt = sbc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= sbc_pkg::S_IDLE;
      sp_r       <= '0;
      fp_r       <= '0;
      depth_r    <= '0;
      pc_r       <= '0;
      halt_r     <= 1'b0;
      final_r    <= '0;
      st_r       <= sbc_pkg::ST_OK;
      code_len_r <= '0;
      out_valid  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sp_r    <= sp_nxt;
      fp_r    <= fp_nxt;
      depth_r <= depth_nxt;
      halt_r  <= halt_nxt;
      final_r <= final_nxt;
      st_r    <= st_nxt;
      // config writes are to arrive only while idle; the block itself does not enforce it
      if (cfg_we && cfg_index == sbc_pkg::CFG_ENTRY_PC) pc_r <= cfg_wdata[15:0];
      else pc_r <= pc_nxt;
      if (cfg_we && cfg_index == sbc_pkg::CFG_CODE_LEN) code_len_r <= cfg_wdata;
      // drop the old result once taken, publish the new one from DONE
      if (state_r == sbc_pkg::S_DONE && state_nxt == sbc_pkg::S_IDLE) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // request capture, operand capture, top refresh and result payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      m_r <= sbc_pkg::opcode_t'(in_mode);
      a_r <= in_operand_a;
      b_r <= in_operand_b;
    end
    if (state_r == sbc_pkg::S_RDB) opa_r <= s_rd;
    if (state_r == sbc_pkg::S_TOPCAP) top_r <= (sp_r == '0) ? 32'd0 : s_rd;
    if (state_r == sbc_pkg::S_DONE && state_nxt == sbc_pkg::S_IDLE) begin
      out_next_pc      <= pc_r;
      out_top_value    <= top_r;
      out_halted       <= halt_r;
      out_return_value <= halt_r ? final_r : 32'd0;
      out_status       <= st_r;
    end
  end

  // bit-serial divider on magnitudes; sign fixed up at the end
  always_ff @(posedge clk) begin
    if (div_start) begin
      dq_r     <= opa_r[31] ? 32'd0 - opa_r : opa_r;
      dvs_r    <= opb[31] ? 32'd0 - opb : opb;
      drem_r   <= '0;
      dcnt_r   <= '0;
      qneg_r   <= opa_r[31] ^ opb[31];
      rneg_r   <= opa_r[31];
      is_mod_r <= (m_r == sbc_pkg::OP_MOD);
    end else if (state_r == sbc_pkg::S_DIV) begin
      dcnt_r <= dcnt_r + 5'd1;
      if (rem_sh >= {1'b0, dvs_r}) begin
        drem_r <= rem_sh - {1'b0, dvs_r};
        dq_r   <= {dq_r[30:0], 1'b1};
      end else begin
        drem_r <= rem_sh;
        dq_r   <= {dq_r[30:0], 1'b0};
      end
    end
  end

  `SBC_ASSERT(a_halt_sticky, clk, rst_n, halt_r |=> halt_r)
  `SBC_ASSERT(a_sp_bound, clk, rst_n, sp_r <= SP_FULL)
  `SBC_ASSERT(a_depth_bound, clk, rst_n, depth_r <= DEPTH_MAX)
  `SBC_ASSERT(a_frame_below_sp, clk, rst_n, fp_r <= sp_r)
endmodule

// ----- tb/stack_bytecode_core_tb.sv -----
// Self-checking testbench for the stack bytecode core: predicted results vs. DUT outputs.
module stack_bytecode_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSTACK = 256;
  localparam int NCALL  = 16;
  // Cycles to let the core drain before a register write.
  localparam int SETTLE = 60;

  typedef struct packed {
    logic [15:0] pc;
    logic [31:0] top;
    logic        halted;
    logic [31:0] retval;
    logic [2:0]  status;
  } outcome_t;

  // Interpreter state mirror plus the queue of results still owed by the DUT.
  class interp_scoreboard;
    logic [31:0] stk [NSTACK];
    bit          written [NSTACK];
    int          sp, fb, depth;
    logic [15:0] ret_pc [NCALL];
    int          saved_fb [NCALL];
    logic [15:0] pc;
    logic [16:0] code_len;
    bit          halted;
    logic [31:0] fin;
    bit          tainted;
    int          fails;
    outcome_t    owed [$];

    function logic [31:0] rd(int i);
      if (!written[i]) tainted = 1;
      return stk[i];
    endfunction

    function void wr(int i, logic [31:0] v);
      stk[i] = v;
      written[i] = 1;
    endfunction

    function void push(logic [31:0] v, inout logic [2:0] st);
      if (sp >= NSTACK) st = sbc_pkg::ST_OVER;
      else begin
        wr(sp, v);
        sp++;
      end
    endfunction

    function logic [31:0] alu2(sbc_pkg::opcode_t m, logic [31:0] x, logic [31:0] y,
                               inout logic [2:0] st);
      logic [31:0] r;
      r = '0;
      case (m)
        sbc_pkg::OP_ADD:  r = x + y;
        sbc_pkg::OP_SUB:  r = x - y;
        sbc_pkg::OP_MUL:  r = x * y;
        sbc_pkg::OP_DIV, sbc_pkg::OP_MOD: begin
          if (y == 0) st = sbc_pkg::ST_DIV_ZERO;
          else if (x == 32'h8000_0000 && y == '1) r = (m == sbc_pkg::OP_DIV) ? x : '0;
          else if (m == sbc_pkg::OP_DIV) r = int'(x) / int'(y);
          else r = int'(x) % int'(y);
        end
        sbc_pkg::OP_EQ:   r = 32'(x == y);
        sbc_pkg::OP_NEQ:  r = 32'(x != y);
        sbc_pkg::OP_LT:   r = 32'(int'(x) < int'(y));
        sbc_pkg::OP_LTE:  r = 32'(int'(x) <= int'(y));
        sbc_pkg::OP_GT:   r = 32'(int'(x) > int'(y));
        sbc_pkg::OP_GTE:  r = 32'(int'(x) >= int'(y));
        sbc_pkg::OP_OR:   r = x | y;
        sbc_pkg::OP_XOR:  r = x ^ y;
        sbc_pkg::OP_AND:  r = x & y;
        sbc_pkg::OP_SHL:  r = x << y[4:0];
        sbc_pkg::OP_SHR:  r = $signed(x) >>> y[4:0];
        sbc_pkg::OP_LAND: r = 32'(x != 0 && y != 0);
        default: r = 32'(x != 0 || y != 0);
      endcase
      return r;
    endfunction

    // Execute one instruction on the mirror; tainted flags a read of unwritten stack.
    function outcome_t run_insn(logic [4:0] m, logic [31:0] ua, logic [15:0] tb);
      longint sa, t;
      logic [31:0] v, x;
      logic [2:0] st;
      logic [15:0] npc;
      int avail, cnt;
      outcome_t o;
      tainted = 0;
      st = sbc_pkg::ST_OK;
      sa = longint'(int'(ua));
      npc = pc + 16'd1;
      if (!halted && {1'b0, pc} >= code_len) begin
        halted = 1;
        fin = sbc_pkg::END_VALUE;
      end else if (!halted) begin
        avail = sp - fb;
        if (m <= sbc_pkg::OP_BNOT) begin
          if (avail < 1) st = sbc_pkg::ST_UNDER;
          else begin
            x = rd(sp - 1);
            case (sbc_pkg::opcode_t'(m))
              sbc_pkg::OP_POS:  v = x;
              sbc_pkg::OP_NEG:  v = -x;
              sbc_pkg::OP_LNOT: v = 32'(x == 0);
              default: v = ~x;
            endcase
            wr(sp - 1, v);
          end
        end else if (m <= sbc_pkg::OP_LOR) begin
          if (avail < 2) st = sbc_pkg::ST_UNDER;
          else begin
            x = rd(sp - 2);
            v = alu2(sbc_pkg::opcode_t'(m), x, rd(sp - 1), st);
            sp--;
            wr(sp - 1, v);
          end
        end else begin
          case (sbc_pkg::opcode_t'(m))
            sbc_pkg::OP_LOAD: begin
              npc = pc + 16'd2;
              v = '0;
              t = fb + sa;
              if (t < 0) st = sbc_pkg::ST_UNDER;
              else if (t >= NSTACK) st = sbc_pkg::ST_OVER;
              else v = rd(int'(t));
              push(v, st);
            end
            sbc_pkg::OP_STL: begin
              npc = pc + 16'd2;
              if (avail < 1) st = sbc_pkg::ST_UNDER;
              else begin
                sp--;
                v = rd(sp);
                t = fb + sa;
                if (t < 0) st = sbc_pkg::ST_UNDER;
                else if (t >= NSTACK) st = sbc_pkg::ST_OVER;
                else wr(int'(t), v);
              end
            end
            sbc_pkg::OP_INT: begin
              npc = pc + 16'd2;
              push(ua, st);
            end
            sbc_pkg::OP_JUMP: npc = pc + 16'd1 + ua[15:0];
            sbc_pkg::OP_BRZ: begin
              npc = pc + 16'd2;
              if (avail < 1) st = sbc_pkg::ST_UNDER;
              else begin
                sp--;
                if (rd(sp) == 0) npc = pc + 16'd1 + ua[15:0];
              end
            end
            sbc_pkg::OP_SPSET: begin
              npc = pc + 16'd2;
              if (sa < 0) begin
                st = sbc_pkg::ST_UNDER;
                sp = fb;
              end else if (fb + sa > NSTACK) begin
                st = sbc_pkg::ST_OVER;
                sp = NSTACK;
              end else sp = fb + int'(sa);
            end
            sbc_pkg::OP_CALL: begin
              npc = pc + 16'd3;
              if (depth >= NCALL) st = sbc_pkg::ST_DEPTH;
              else begin
                // Clamp the argument count to what the caller frame holds.
                if (sa < 0) begin
                  st = sbc_pkg::ST_UNDER;
                  cnt = 0;
                end else if (sa > avail) begin
                  st = sbc_pkg::ST_UNDER;
                  cnt = avail;
                end else cnt = int'(sa);
                ret_pc[depth] = npc;
                saved_fb[depth] = fb;
                depth++;
                fb = sp - cnt;
                npc = tb;
              end
            end
            sbc_pkg::OP_RET: begin
              v = '0;
              if (avail < 1) st = sbc_pkg::ST_UNDER;
              else v = rd(sp - 1);
              if (depth == 0) begin
                halted = 1;
                fin = v;
                npc = pc;
              end else begin
                if (fb >= NSTACK) begin
                  st = sbc_pkg::ST_OVER;
                  sp = fb;
                end else begin
                  wr(fb, v);
                  sp = fb + 1;
                end
                depth--;
                fb = saved_fb[depth];
                npc = ret_pc[depth];
              end
            end
            default: ;
          endcase
        end
        pc = npc;
        if (!halted && {1'b0, pc} >= code_len) begin
          halted = 1;
          fin = sbc_pkg::END_VALUE;
        end
      end
      o.pc = pc;
      o.top = (sp > 0) ? rd(sp - 1) : '0;
      o.halted = halted;
      o.retval = halted ? fin : '0;
      o.status = st;
      return o;
    endfunction

    function void note_request(logic [4:0] m, logic [31:0] a, logic [15:0] b);
      owed.push_back(run_insn(m, a, b));
    endfunction

    function void cmp(string name, logic [31:0] e, logic [31:0] g);
      if (e !== g) begin
        $display("%0t: %s mismatch: expected %h actual %h", $time, name, e, g);
        fails++;
      end
    endfunction

    function void check_result(outcome_t got);
      outcome_t e;
      if (owed.size() == 0) begin
        $display("%0t: result with nothing expected: actual %h", $time, got);
        fails++;
        return;
      end
      e = owed.pop_front();
      cmp("next_pc", e.pc, got.pc);
      cmp("top_value", e.top, got.top);
      cmp("halted", e.halted, got.halted);
      cmp("return_value", e.retval, got.retval);
      cmp("status", e.status, got.status);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [4:0]  in_mode = '0;
  logic [31:0] in_operand_a = '0;
  logic [15:0] in_operand_b = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_next_pc;
  logic [31:0] out_top_value;
  logic        out_halted;
  logic [31:0] out_return_value;
  logic [2:0]  out_status;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [16:0] cfg_wdata = '0;

  interp_scoreboard sb;
  bit calm = 0;       // no idling on either side near the end
  int stall_left = 0;
  int call_bias = 0;  // percent of extra calls, used to drive deep nesting

  stack_bytecode_core DUT (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Drop out_ready in random bursts; hold it high once calm.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= (stall_left == 1);
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(1, 16);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Outputs and ready are stable between edges: a handshake seen here fires at the next edge.
  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result({out_next_pc, out_top_value, out_halted, out_return_value, out_status});
  end

  // Drop the request line and wait until every owed result is back.
  task automatic hold_off();
    in_valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
  endtask

  task automatic wait_drained();
    hold_off();
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [16:0] data);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == sbc_pkg::CFG_CODE_LEN) sb.code_len = data;
    else sb.pc = data[15:0];
  endtask

  // Send one request if it stays inside the contract; report whether it went out.
  task automatic issue(logic [4:0] m, logic [31:0] a, logic [15:0] b, bit allow_halt,
                       output bit sent);
    interp_scoreboard probe;
    outcome_t o;
    bit acc;
    probe = new sb;
    o = probe.run_insn(m, a, b);
    sent = !probe.tainted && (allow_halt || !o.halted);
    if (!sent) return;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= m;
    in_operand_a <= a;
    in_operand_b <= b;
    do begin
      @(negedge clk);
      acc = in_ready;
      @(posedge clk);
    end while (!acc);
    sb.note_request(m, a, b);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 1) ? 32'h0 : 32'hffff_ffff;
      3: return $urandom_range(0, 9) - 4;
      default: return $urandom;
    endcase
  endfunction

  // Mostly well-formed instructions with valid locals; some wild operands.
  task automatic random_insn();
    logic [4:0] m;
    logic [31:0] a;
    logic [15:0] b;
    int r, avail;
    bit sent;
    do begin
      r = $urandom_range(0, 99);
      avail = sb.sp - sb.fb;
      a = pick_word();
      b = 16'($urandom);
      if ($urandom_range(0, 99) < call_bias) r = 85;
      if (r < 22) m = sbc_pkg::OP_INT;
      else if (r < 32) begin
        m = sbc_pkg::OP_LOAD;
        if ($urandom_range(0, 3) != 0) a = $urandom_range(0, avail + 1) - 1;
      end else if (r < 40) begin
        m = sbc_pkg::OP_STL;
        if ($urandom_range(0, 3) != 0) a = $urandom_range(0, avail + 1) - 1;
      end else if (r < 65) m = 5'($urandom_range(sbc_pkg::OP_POS, sbc_pkg::OP_LOR));
      else if (r < 70) m = sbc_pkg::OP_JUMP;
      else if (r < 76) m = sbc_pkg::OP_BRZ;
      else if (r < 82) begin
        m = sbc_pkg::OP_SPSET;
        if ($urandom_range(0, 3) != 0) a = avail - $urandom_range(0, 3);
      end else if (r < 89) begin
        m = sbc_pkg::OP_CALL;
        if ($urandom_range(0, 3) != 0) a = $urandom_range(0, 3);
      end else if (r < 97) m = sbc_pkg::OP_RET;
      else m = 5'($urandom_range(0, 31));
      issue(m, a, b, 0, sent);
    end while (!sent);
  endtask

  initial begin
    int k;
    logic [15:0] epc;
    bit sent;
    sb = new;
    sb.fails = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(sbc_pkg::CFG_CODE_LEN, 17'h10000);
    write_reg(sbc_pkg::CFG_ENTRY_PC, 17'd0);

    // Directed: empty-stack pops, divide corners, shifts, out-of-range locals, calls.
    issue(sbc_pkg::OP_ADD, 0, 0, 0, sent);
    issue(sbc_pkg::OP_INT, 32'h8000_0000, 0, 0, sent);
    issue(sbc_pkg::OP_INT, 32'hffff_ffff, 0, 0, sent);
    issue(sbc_pkg::OP_DIV, 0, 0, 0, sent);
    issue(sbc_pkg::OP_INT, 32'hffff_ffff, 0, 0, sent);
    issue(sbc_pkg::OP_MOD, 0, 0, 0, sent);
    issue(sbc_pkg::OP_INT, 32'd0, 0, 0, sent);
    issue(sbc_pkg::OP_DIV, 0, 0, 0, sent);
    issue(sbc_pkg::OP_NEG, 0, 0, 0, sent);
    issue(sbc_pkg::OP_LNOT, 0, 0, 0, sent);
    issue(sbc_pkg::OP_BNOT, 0, 0, 0, sent);
    issue(sbc_pkg::OP_INT, 32'd33, 0, 0, sent);
    issue(sbc_pkg::OP_SHL, 0, 0, 0, sent);
    issue(sbc_pkg::OP_INT, 32'h7fff_ffff, 0, 0, sent);
    issue(sbc_pkg::OP_INT, 32'd63, 0, 0, sent);
    issue(sbc_pkg::OP_SHR, 0, 0, 0, sent);
    issue(sbc_pkg::OP_LOAD, -1000, 0, 0, sent);
    issue(sbc_pkg::OP_LOAD, 1000, 0, 0, sent);
    issue(sbc_pkg::OP_STL, 300, 0, 0, sent);
    issue(sbc_pkg::OP_CALL, 50, 16'hffff, 0, sent);
    issue(sbc_pkg::OP_RET, 0, 0, 0, sent);
    issue(sbc_pkg::OP_CALL, -1, 16'h0100, 0, sent);
    issue(sbc_pkg::OP_RET, 0, 0, 0, sent);
    issue(sbc_pkg::OP_SPSET, -1, 0, 0, sent);
    issue(sbc_pkg::OP_BRZ, 7, 0, 0, sent);
    issue(sbc_pkg::OP_JUMP, -5, 0, 0, sent);
    issue(sbc_pkg::OP_RSV0, 0, 0, 0, sent);
    issue(sbc_pkg::OP_RSV1, 0, 0, 0, sent);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: epc = 16'($urandom);
        1: begin
          write_reg(sbc_pkg::CFG_CODE_LEN, 17'd40000);
          epc = 16'($urandom_range(0, 39000));
        end
        2: begin
          write_reg(sbc_pkg::CFG_CODE_LEN, 17'h10000);
          epc = 16'hffff;
        end
        default: epc = 16'd0;
      endcase
      write_reg(sbc_pkg::CFG_ENTRY_PC, {1'b0, epc});
      if (ph == 3) calm = 1;
      for (k = 0; k < 480; k++) begin
        call_bias = (ph == 1 && k >= 100 && k < 140) ? 70 : 0;
        // Hold off once mid-run until every result is back.
        if (ph == 0 && k == 240) hold_off();
        random_insn();
      end
      // Fill the stack to the top, then push once more onto the full stack.
      if (ph == 2) begin
        while (sb.sp < NSTACK) issue(sbc_pkg::OP_INT, pick_word(), 0, 0, sent);
        issue(sbc_pkg::OP_INT, 32'h1234_5678, 0, 0, sent);
        issue(sbc_pkg::OP_SPSET, 3, 0, 0, sent);
      end
    end

    // Halt once: either unwind and return from top level, or run off code end.
    if ($urandom_range(0, 1)) begin
      while (!sb.halted) begin
        issue(sbc_pkg::OP_RET, pick_word(), 0, 1, sent);
        if (!sent) issue(sbc_pkg::OP_INT, pick_word(), 0, 1, sent);
      end
    end else begin
      write_reg(sbc_pkg::CFG_CODE_LEN, {1'b0, sb.pc});
      random_insn_halting();
    end
    // Steps while halted repeat the final state.
    repeat (8) issue(5'($urandom_range(0, 31)), $urandom, 16'($urandom), 1, sent);
    write_reg(sbc_pkg::CFG_CODE_LEN, 17'd0);
    write_reg(sbc_pkg::CFG_ENTRY_PC, 17'hffff);
    repeat (4) issue(5'($urandom_range(0, 31)), $urandom, 16'($urandom), 1, sent);

    wait_drained();
    if (sb.fails == 0 && sb.owed.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // Pc already at code end: any instruction halts with the end value.
  task automatic random_insn_halting();
    bit sent;
    do issue(sbc_pkg::OP_INT, pick_word(), 0, 1, sent); while (!sent);
  endtask

  initial begin
    #12_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
